// ===== design/lps_pkg.sv =====
`default_nettype none

package lps_pkg;

    // Counter and histogram geometry.
    localparam int COUNT_WIDTH = 32;
    localparam int CLASS_BINS  = 32;
    localparam int RETURN_BINS = 5;
    localparam int PULSE_BINS  = 8;
    localparam int FLAG_BITS   = 3;
    localparam int NUM_ATTR    = 12;

    // Attribute slots of the small min/max pairs.
    localparam int ATTR_INTENSITY = 0;
    localparam int ATTR_RETNUM    = 1;
    localparam int ATTR_NUMRET    = 2;
    localparam int ATTR_SCANDIR   = 3;
    localparam int ATTR_EDGE      = 4;
    localparam int ATTR_SCAN      = 5;
    localparam int ATTR_USER      = 6;
    localparam int ATTR_CLASS     = 7;
    localparam int ATTR_SOURCE    = 8;
    localparam int ATTR_RED       = 9;
    localparam int ATTR_GREEN     = 10;
    localparam int ATTR_BLUE      = 11;

    // Codes of the extents run.
    localparam logic [5:0] EXT_COUNT_CODE     = 6'd0;
    localparam logic [5:0] EXT_COORD_LAST     = 6'd6;
    localparam logic [5:0] EXT_INT_MIN_CODE   = 6'd7;
    localparam logic [5:0] EXT_INT_MAX_CODE   = 6'd8;
    localparam logic [5:0] EXT_TIME_MIN_CODE  = 6'd9;
    localparam logic [5:0] EXT_TIME_MAX_CODE  = 6'd10;
    localparam logic [5:0] EXT_ATTR_BASE_CODE = 6'd11;
    localparam logic [5:0] EXT_LAST_CODE      = 6'd32;

    // Codes of the histogram run.
    localparam logic [5:0] HIST_PULSE_BASE = 6'd5;
    localparam logic [5:0] HIST_CLASS_BASE = 6'd13;
    localparam logic [5:0] HIST_FLAG_BASE  = 6'd45;
    localparam logic [5:0] HIST_LAST_CODE  = 6'd47;

    typedef logic [COUNT_WIDTH-1:0] count_t;

    typedef enum logic [1:0] {
        ACT_ADD_POINT       = 2'd0,
        ACT_DUMP_EXTENTS    = 2'd1,
        ACT_DUMP_HISTOGRAMS = 2'd2,
        ACT_CLEAR           = 2'd3
    } action_t;

    typedef struct packed {
        action_t            action;
        logic signed [31:0] x_coord;
        logic signed [31:0] y_coord;
        logic signed [31:0] z_coord;
        logic [15:0]        intensity;
        logic signed [63:0] gps_time;
        logic [7:0]         return_byte;
        logic signed [7:0]  scan_rank;
        logic [7:0]         user_byte;
        logic [7:0]         class_byte;
        logic [15:0]        source_id;
        logic [47:0]        color_rgb;
    } point_item_t;

    typedef struct packed {
        logic [5:0]         stat_code;
        logic signed [63:0] stat_value;
        logic               last_flag;
    } stat_item_t;

endpackage

`default_nettype wire

// ===== design/lidar_point_statistics.sv =====
// Lidar point record statistics.
// Point records and commands arrive on the item channel (item_valid, item_stall,
// item) and results leave on the stat channel (stat_valid, stat_stall, stat).
// An item is taken into an input register on its transfer; the following clock
// edge folds an add-point item into the min/max registers and counters, or
// applies a clear. Add-point and clear items give no results and are accepted
// one per cycle with no gaps while no dump is under way.
// A dump-extents item gives 33 results and a dump-histograms item 48, one per
// cycle while the receiver does not stall, the first registered once the item
// is in the input register and the output register is free. The dump sequencer
// reads the statistics through one output multiplexer, so item_stall stays high
// until the last result of a run moves into the output register.
// When the receiver stalls, the output register holds its result and the dump
// sequencer waits; adds and clears that follow are held at the input.
// Reset clears every statistic, the point count and both channels; the first
// point after reset or clear seeds all minima and maxima. Counters saturate
// at all ones.
`default_nettype none

module lidar_point_statistics import lps_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  item_valid,
    output logic       item_stall,
    input  wire point_item_t item,
    output logic       stat_valid,
    input  wire logic  stat_stall,
    output stat_item_t stat
);

    // Input stage.
    point_item_t item_reg;
    logic        item_valid_reg;
    logic        item_valid_next;
    logic [5:0]  dump_index_reg;
    logic [5:0]  dump_index_next;

    // Output stage.
    stat_item_t  stat_reg;
    stat_item_t  stat_next;
    logic        stat_valid_reg;
    logic        stat_valid_next;

    // Extent registers.
    logic signed [31:0] coord_min_reg [3];
    logic signed [31:0] coord_max_reg [3];
    logic signed [31:0] coord_min_next [3];
    logic signed [31:0] coord_max_next [3];
    logic signed [31:0] coord_val [3];
    logic signed [63:0] time_min_reg;
    logic signed [63:0] time_max_reg;
    logic signed [63:0] time_min_next;
    logic signed [63:0] time_max_next;
    logic [15:0]        attr_min_reg [NUM_ATTR];
    logic [15:0]        attr_max_reg [NUM_ATTR];
    logic [15:0]        attr_min_next [NUM_ATTR];
    logic [15:0]        attr_max_next [NUM_ATTR];
    logic [15:0]        attr_val [NUM_ATTR];

    // Counters.
    count_t point_count;
    count_t return_count [RETURN_BINS];
    count_t pulse_count [PULSE_BINS];
    count_t class_count [CLASS_BINS];
    count_t flag_count [FLAG_BITS];

    // Control.
    logic       is_add;
    logic       is_clear;
    logic       is_dump;
    logic       is_extents;
    logic       out_free;
    logic       emit;
    logic [5:0] last_code;
    logic       dump_end;
    logic       stage_free;
    logic       first_point;
    logic [2:0] ret_num;
    logic [2:0] num_ret;
    logic [2:0] ret_bin;
    logic [4:0] class_idx;

    // Dump read selection.
    logic [5:0]         coord_off;
    logic [1:0]         coord_idx;
    logic [5:0]         attr_off;
    logic [3:0]         attr_idx;
    logic [5:0]         hist_off;
    logic signed [63:0] ext_value;
    logic signed [63:0] hist_value;

    // Ordered compare: the scan angle slot holds a signed value.
    function automatic logic attr_less(input int idx, input logic [15:0] a,
                                       input logic [15:0] b);
        logic result;
        if (idx == ATTR_SCAN)
        begin
            result = ($signed(a) < $signed(b));
        end
        else
        begin
            result = (a < b);
        end
        return result;
    endfunction

    // Widen an attribute to the result width.
    function automatic logic signed [63:0] attr_widen(input logic [3:0] idx,
                                                      input logic [15:0] v);
        logic signed [63:0] result;
        if (idx == 4'(ATTR_SCAN))
        begin
            result = {{48{v[15]}}, v};
        end
        else
        begin
            result = {48'd0, v};
        end
        return result;
    endfunction

    function automatic logic signed [63:0] count_widen(input count_t c);
        return {{(64 - COUNT_WIDTH){1'b0}}, c};
    endfunction

    // Decode of the registered item.
    assign is_add     = item_valid_reg && (item_reg.action == ACT_ADD_POINT);
    assign is_clear   = item_valid_reg && (item_reg.action == ACT_CLEAR);
    assign is_extents = (item_reg.action == ACT_DUMP_EXTENTS);
    assign is_dump    = item_valid_reg && (is_extents ||
                        (item_reg.action == ACT_DUMP_HISTOGRAMS));
    assign last_code  = is_extents ? EXT_LAST_CODE : HIST_LAST_CODE;

    // A dump step moves one result whenever the output register can take it.
    assign out_free   = !stat_valid_reg || !stat_stall;
    assign emit       = is_dump && out_free;
    assign dump_end   = emit && (dump_index_reg == last_code);
    assign stage_free = !is_dump || dump_end;
    assign item_stall = !stage_free;

    always_comb
    begin
        item_valid_next = item_valid_reg;
        if (stage_free)
        begin
            item_valid_next = item_valid;
        end
    end

    always_comb
    begin
        dump_index_next = dump_index_reg;
        if (dump_end)
        begin
            dump_index_next = '0;
        end
        else if (emit)
        begin
            dump_index_next = dump_index_reg + 6'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            dump_index_reg <= '0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            dump_index_reg <= dump_index_next;
        end
    end

    // Payload is loaded on each transfer.
    always_ff @(posedge clk)
    begin
        if (item_valid && stage_free)
        begin
            item_reg <= item;
        end
    end

    // Fields of the point.
    assign ret_num   = item_reg.return_byte[2:0];
    assign num_ret   = item_reg.return_byte[5:3];
    assign ret_bin   = (ret_num == 3'd0) ? 3'd0 : (ret_num - 3'd1);
    assign class_idx = item_reg.class_byte[4:0];
    assign first_point = (point_count == '0);

    assign coord_val[0] = item_reg.x_coord;
    assign coord_val[1] = item_reg.y_coord;
    assign coord_val[2] = item_reg.z_coord;

    assign attr_val[ATTR_INTENSITY] = item_reg.intensity;
    assign attr_val[ATTR_RETNUM]    = {13'd0, ret_num};
    assign attr_val[ATTR_NUMRET]    = {13'd0, num_ret};
    assign attr_val[ATTR_SCANDIR]   = {15'd0, item_reg.return_byte[6]};
    assign attr_val[ATTR_EDGE]      = {15'd0, item_reg.return_byte[7]};
    assign attr_val[ATTR_SCAN]      = {{8{item_reg.scan_rank[7]}}, item_reg.scan_rank};
    assign attr_val[ATTR_USER]      = {8'd0, item_reg.user_byte};
    assign attr_val[ATTR_CLASS]     = {8'd0, item_reg.class_byte};
    assign attr_val[ATTR_SOURCE]    = item_reg.source_id;
    assign attr_val[ATTR_RED]       = item_reg.color_rgb[47:32];
    assign attr_val[ATTR_GREEN]     = item_reg.color_rgb[31:16];
    assign attr_val[ATTR_BLUE]      = item_reg.color_rgb[15:0];

    // Min/max folding: the first point seeds both sides, clear zeroes them.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            coord_min_next[i] = coord_min_reg[i];
            coord_max_next[i] = coord_max_reg[i];
            if (is_clear)
            begin
                coord_min_next[i] = '0;
                coord_max_next[i] = '0;
            end
            else if (is_add)
            begin
                if (first_point || (coord_val[i] < coord_min_reg[i]))
                begin
                    coord_min_next[i] = coord_val[i];
                end
                if (first_point || (coord_max_reg[i] < coord_val[i]))
                begin
                    coord_max_next[i] = coord_val[i];
                end
            end
        end
    end

    always_comb
    begin
        time_min_next = time_min_reg;
        time_max_next = time_max_reg;
        if (is_clear)
        begin
            time_min_next = '0;
            time_max_next = '0;
        end
        else if (is_add)
        begin
            if (first_point || (item_reg.gps_time < time_min_reg))
            begin
                time_min_next = item_reg.gps_time;
            end
            if (first_point || (time_max_reg < item_reg.gps_time))
            begin
                time_max_next = item_reg.gps_time;
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < NUM_ATTR; i++)
        begin
            attr_min_next[i] = attr_min_reg[i];
            attr_max_next[i] = attr_max_reg[i];
            if (is_clear)
            begin
                attr_min_next[i] = '0;
                attr_max_next[i] = '0;
            end
            else if (is_add)
            begin
                if (first_point || attr_less(i, attr_val[i], attr_min_reg[i]))
                begin
                    attr_min_next[i] = attr_val[i];
                end
                if (first_point || attr_less(i, attr_max_reg[i], attr_val[i]))
                begin
                    attr_max_next[i] = attr_val[i];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                coord_min_reg[i] <= '0;
                coord_max_reg[i] <= '0;
            end
            time_min_reg <= '0;
            time_max_reg <= '0;
            for (int i = 0; i < NUM_ATTR; i++)
            begin
                attr_min_reg[i] <= '0;
                attr_max_reg[i] <= '0;
            end
        end
        else
        begin
            coord_min_reg <= coord_min_next;
            coord_max_reg <= coord_max_next;
            time_min_reg  <= time_min_next;
            time_max_reg  <= time_max_next;
            attr_min_reg  <= attr_min_next;
            attr_max_reg  <= attr_max_next;
        end
    end

    // Saturating counters, one per bin.
    lps_sat_counter u_point_count
    (
        .clk   (clk),
        .rst_n (rst_n),
        .clear (is_clear),
        .bump  (is_add),
        .count (point_count)
    );

    for (genvar g = 0; g < RETURN_BINS; g++)
    begin : g_return
        lps_sat_counter u_count
        (
            .clk   (clk),
            .rst_n (rst_n),
            .clear (is_clear),
            .bump  (is_add && (ret_bin == 3'(g))),
            .count (return_count[g])
        );
    end

    for (genvar g = 0; g < PULSE_BINS; g++)
    begin : g_pulse
        lps_sat_counter u_count
        (
            .clk   (clk),
            .rst_n (rst_n),
            .clear (is_clear),
            .bump  (is_add && (num_ret == 3'(g))),
            .count (pulse_count[g])
        );
    end

    for (genvar g = 0; g < CLASS_BINS; g++)
    begin : g_class
        lps_sat_counter u_count
        (
            .clk   (clk),
            .rst_n (rst_n),
            .clear (is_clear),
            .bump  (is_add && (class_idx == 5'(g))),
            .count (class_count[g])
        );
    end

    for (genvar g = 0; g < FLAG_BITS; g++)
    begin : g_flag
        lps_sat_counter u_count
        (
            .clk   (clk),
            .rst_n (rst_n),
            .clear (is_clear),
            .bump  (is_add && item_reg.class_byte[5 + g]),
            .count (flag_count[g])
        );
    end

    // Extents run: the count, then min/max pairs; odd codes are minima.
    assign coord_off = dump_index_reg - 6'd1;
    assign coord_idx = coord_off[2:1];
    assign attr_off  = dump_index_reg - EXT_ATTR_BASE_CODE;
    assign attr_idx  = attr_off[4:1] + 4'd1;

    always_comb
    begin
        ext_value = '0;
        priority if (dump_index_reg == EXT_COUNT_CODE)
        begin
            ext_value = count_widen(point_count);
        end
        else if (dump_index_reg <= EXT_COORD_LAST)
        begin
            ext_value = dump_index_reg[0] ?
                        {{32{coord_min_reg[coord_idx][31]}}, coord_min_reg[coord_idx]} :
                        {{32{coord_max_reg[coord_idx][31]}}, coord_max_reg[coord_idx]};
        end
        else if (dump_index_reg == EXT_INT_MIN_CODE)
        begin
            ext_value = {48'd0, attr_min_reg[ATTR_INTENSITY]};
        end
        else if (dump_index_reg == EXT_INT_MAX_CODE)
        begin
            ext_value = {48'd0, attr_max_reg[ATTR_INTENSITY]};
        end
        else if (dump_index_reg == EXT_TIME_MIN_CODE)
        begin
            ext_value = time_min_reg;
        end
        else if (dump_index_reg == EXT_TIME_MAX_CODE)
        begin
            ext_value = time_max_reg;
        end
        else if (dump_index_reg <= EXT_LAST_CODE)
        begin
            ext_value = dump_index_reg[0] ?
                        attr_widen(attr_idx, attr_min_reg[attr_idx]) :
                        attr_widen(attr_idx, attr_max_reg[attr_idx]);
        end
        else
        begin
            ext_value = '0;
        end
    end

    // Histogram run: return bins, pulse bins, class bins, flag counts.
    always_comb
    begin
        hist_off   = '0;
        hist_value = '0;
        priority if (dump_index_reg < HIST_PULSE_BASE)
        begin
            hist_value = count_widen(return_count[dump_index_reg[2:0]]);
        end
        else if (dump_index_reg < HIST_CLASS_BASE)
        begin
            hist_off   = dump_index_reg - HIST_PULSE_BASE;
            hist_value = count_widen(pulse_count[hist_off[2:0]]);
        end
        else if (dump_index_reg < HIST_FLAG_BASE)
        begin
            hist_off   = dump_index_reg - HIST_CLASS_BASE;
            hist_value = count_widen(class_count[hist_off[4:0]]);
        end
        else if (dump_index_reg <= HIST_LAST_CODE)
        begin
            hist_off   = dump_index_reg - HIST_FLAG_BASE;
            hist_value = count_widen(flag_count[hist_off[1:0]]);
        end
        else
        begin
            hist_value = '0;
        end
    end

    // Output register: loaded by a dump step, emptied by a transfer.
    always_comb
    begin
        stat_valid_next = stat_valid_reg;
        stat_next       = stat_reg;
        if (emit)
        begin
            stat_valid_next      = 1'b1;
            stat_next.stat_code  = dump_index_reg;
            stat_next.stat_value = is_extents ? ext_value : hist_value;
            stat_next.last_flag  = (dump_index_reg == last_code);
        end
        else if (!stat_stall)
        begin
            stat_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stat_valid_reg <= 1'b0;
        end
        else
        begin
            stat_valid_reg <= stat_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        stat_reg <= stat_next;
    end

    assign stat_valid = stat_valid_reg;
    assign stat       = stat_reg;

endmodule

`default_nettype wire

// ===== design/lps_sat_counter.sv =====
`default_nettype none

module lps_sat_counter import lps_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic clear,
    input  wire logic bump,
    output count_t    count
);

    count_t count_reg;
    count_t count_next;

    // Increment that holds at all ones; clear wins over an increment.
    always_comb
    begin
        count_next = count_reg;
        if (clear)
        begin
            count_next = '0;
        end
        else if (bump && (count_reg != '1))
        begin
            count_next = count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign count = count_reg;

endmodule

`default_nettype wire
